>>> hdl/hsv_pkg.sv
`default_nettype none

package hsv_pkg;

	// Q1.15 unity for saturation and brightness
	localparam logic [15:0] Q_ONE = 16'd32768;
	// one full sector width in the Q0.16 weight
	localparam logic [16:0] W_ONE = 17'h10000;

	// hue sector: high channel, then the middle channel
	typedef enum logic [2:0] {
		SEC_RG = 3'd0,
		SEC_GR = 3'd1,
		SEC_GB = 3'd2,
		SEC_BG = 3'd3,
		SEC_BR = 3'd4,
		SEC_RB = 3'd5
	} sector_t;

	// input word
	typedef struct packed {
		logic [15:0] hue_turn;
		logic [15:0] saturation;
		logic [15:0] brightness;
	} pix_t;

	// output word
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// after stage 1: clamped levels, sector and ramp weight
	typedef struct packed {
		sector_t     sector;
		logic [16:0] weight;
		logic [15:0] hi;
		logic [15:0] oms;
	} prep_t;

	// after stage 4: three levels in Q1.15
	typedef struct packed {
		sector_t     sector;
		logic [15:0] hi;
		logic [15:0] med;
		logic [15:0] lo;
	} level_t;

	// (level * 255) >> 15, level <= 1.0
	function automatic logic [7:0] to_byte(input logic [15:0] level);
		logic [23:0] x;
		x = {level, 8'd0} - {8'd0, level};
		return x[22:15];
	endfunction

endpackage

`default_nettype wire

>>> hdl/hsv_prep.sv
`default_nettype none

module hsv_prep import hsv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  valid,
	input  wire pix_t  pix,
	output logic       valid_s1,
	output prep_t      prep_s1
);

	logic [15:0] s_c;
	logic [15:0] v_c;
	logic [18:0] t;
	logic [15:0] f;
	logic [16:0] w;

	// clamp, split hue into sector and fraction
	always_comb begin
		s_c = (pix.saturation > Q_ONE) ? Q_ONE : pix.saturation;
		v_c = (pix.brightness > Q_ONE) ? Q_ONE : pix.brightness;
		t   = {1'b0, pix.hue_turn, 2'b00} + {2'b00, pix.hue_turn, 1'b0};
		f   = t[15:0];
		// odd sectors ramp downward
		w   = t[16] ? (W_ONE - {1'b0, f}) : {1'b0, f};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prep_s1.sector <= sector_t'(t[18:16]);
			prep_s1.weight <= w;
			prep_s1.hi     <= v_c;
			prep_s1.oms    <= Q_ONE - s_c;
		end
	end

endmodule

`default_nettype wire

>>> hdl/hsv_ramp.sv
`default_nettype none

module hsv_ramp import hsv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  adv,
	input  wire logic  valid_s1,
	input  wire prep_t prep_s1,
	output logic       valid_s4,
	output level_t     lvl_s4
);

	logic        valid_s2;
	logic        valid_s3;
	sector_t     sector_s2;
	sector_t     sector_s3;
	logic [15:0] hi_s2;
	logic [15:0] hi_s3;
	logic [15:0] lo_s2;
	logic [15:0] lo_s3;
	logic [16:0] weight_s2;
	logic [15:0] ramp_s3;
	logic [31:0] lo_prod;
	logic [15:0] span;
	logic [32:0] ramp_prod;

	// low level V*(1-S), then span times weight
	always_comb begin
		lo_prod   = prep_s1.hi * prep_s1.oms;
		span      = hi_s2 - lo_s2;
		ramp_prod = span * weight_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 2
			sector_s2 <= prep_s1.sector;
			hi_s2     <= prep_s1.hi;
			lo_s2     <= lo_prod[30:15];
			weight_s2 <= prep_s1.weight;
			// stage 3
			sector_s3 <= sector_s2;
			hi_s3     <= hi_s2;
			lo_s3     <= lo_s2;
			ramp_s3   <= ramp_prod[31:16];
			// stage 4: middle level never exceeds the high level
			lvl_s4.sector <= sector_s3;
			lvl_s4.hi     <= hi_s3;
			lvl_s4.lo     <= lo_s3;
			lvl_s4.med    <= lo_s3 + ramp_s3;
		end
	end

endmodule

`default_nettype wire

>>> hdl/hsv_pack.sv
`default_nettype none

module hsv_pack import hsv_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   adv,
	input  wire logic   valid_s4,
	input  wire level_t lvl_s4,
	output logic        valid_s5,
	output rgb_t        rgb_s5
);

	logic [7:0] h8;
	logic [7:0] m8;
	logic [7:0] l8;
	rgb_t       rgb_c;

	// scale to bytes and route by sector
	always_comb begin
		h8 = to_byte(lvl_s4.hi);
		m8 = to_byte(lvl_s4.med);
		l8 = to_byte(lvl_s4.lo);
		unique case (lvl_s4.sector)
			SEC_RG:  rgb_c = '{red: h8, green: m8, blue: l8};
			SEC_GR:  rgb_c = '{red: m8, green: h8, blue: l8};
			SEC_GB:  rgb_c = '{red: l8, green: h8, blue: m8};
			SEC_BG:  rgb_c = '{red: l8, green: m8, blue: h8};
			SEC_BR:  rgb_c = '{red: m8, green: l8, blue: h8};
			default: rgb_c = '{red: h8, green: l8, blue: m8};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s5 <= rgb_c;
		end
	end

endmodule

`default_nettype wire

>>> hdl/hsv_to_rgb_converter.sv
`default_nettype none

// HSV to RGB pixel converter. Hue is a 16-bit fraction of a turn; saturation
// and brightness are Q1.15 (32768 = 1.0, larger values clamp to 1.0). Each
// pixel gives 8-bit red, green and blue, each level times 255 truncated.
// Five-stage pipeline: one pixel per clock while no stall holds the pipeline.
// The stages share one advance enable, so a stall on rgb while the output
// register holds a word freezes the whole pipeline and raises pix_stall.

module hsv_to_rgb_converter import hsv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pix_valid,
	output logic       pix_stall,
	input  wire pix_t  pix,
	output logic       rgb_valid,
	input  wire logic  rgb_stall,
	output rgb_t       rgb
);

	logic   adv;
	logic   valid_s1;
	logic   valid_s4;
	prep_t  prep_s1;
	level_t lvl_s4;

	// pipeline moves unless a full output word is held
	assign adv       = !(rgb_valid && rgb_stall);
	assign pix_stall = !adv;

	hsv_prep u_prep (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid    (pix_valid),
		.pix      (pix),
		.valid_s1 (valid_s1),
		.prep_s1  (prep_s1)
	);

	hsv_ramp u_ramp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.prep_s1  (prep_s1),
		.valid_s4 (valid_s4),
		.lvl_s4   (lvl_s4)
	);

	hsv_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s4 (valid_s4),
		.lvl_s4   (lvl_s4),
		.valid_s5 (rgb_valid),
		.rgb_s5   (rgb)
	);

	// an empty output register never holds back the input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> !pix_stall)
		else $error("input stalled with empty output");

	// a taken word is replaced by the word from stage 4
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && !rgb_stall |=> rgb_valid == $past(valid_s4))
		else $error("output word lost or invented");

	// the middle level lies between low and high
	a_med_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (lvl_s4.med >= lvl_s4.lo) && (lvl_s4.med <= lvl_s4.hi))
		else $error("middle level out of range");

endmodule

`default_nettype wire
